// ===== src/tiled_to_linear_detile_addr_macros.svh =====
// Assertion macros for the checker file.
`ifndef TILED_TO_LINEAR_DETILE_ADDR_MACROS_SVH
`define TILED_TO_LINEAR_DETILE_ADDR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define T2LD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define T2LD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/t2ld_pkg.sv =====
package t2ld_pkg;

  localparam int ROWS_PER_BLOCK = 16;
  localparam int ROW_CNT_W      = $clog2(ROWS_PER_BLOCK);

  localparam int DIM_W    = 13;
  localparam int COORD_W  = 12;
  localparam int SRC_W    = 25;
  localparam int DST_W    = 24;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd1088;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CHROMA_MODE  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] block_col;
    logic [COORD_W-1:0] block_row;
  } in_word_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_offset;
    logic [DST_W-1:0] dst_offset;
    logic [DST_W-1:0] v_dst_offset;
    logic             skip_row;
    logic             last_row;
  } out_word_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             chroma_mode;
  } cfg_t;

  // One row request from the sequencer to the address pipeline.
  typedef struct packed {
    logic                 valid;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [ROW_CNT_W-1:0] rnum;
    logic                 last;
  } row_req_t;

endpackage

// ===== src/t2ld_row_seq.sv =====
module t2ld_row_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  t2ld_pkg::in_word_t in_word,
  input  logic               take,
  output t2ld_pkg::row_req_t req
);
  import t2ld_pkg::*;

  localparam logic [ROW_CNT_W-1:0] LAST_ROW = ROW_CNT_W'(ROWS_PER_BLOCK - 1);

  logic                 busy_r, busy_nxt;
  logic [ROW_CNT_W-1:0] rnum_r, rnum_nxt;
  in_word_t             item_r;
  logic                 issue, issue_last, accept;

  // Issue one row per cycle while the pipeline moves
  assign issue      = busy_r && take;
  assign issue_last = issue && (rnum_r == LAST_ROW);
  assign in_stall   = busy_r && !issue_last;
  assign accept     = in_valid && !in_stall;

  assign req.valid = busy_r;
  assign req.col   = item_r.block_col;
  assign req.row   = item_r.block_row;
  assign req.rnum  = rnum_r;
  assign req.last  = (rnum_r == LAST_ROW);

  // Advance the row counter, reload on a new word
  always_comb begin
    busy_nxt = busy_r;
    rnum_nxt = rnum_r;
    if (accept) begin
      busy_nxt = 1'b1;
      rnum_nxt = '0;
    end else if (issue_last) begin
      busy_nxt = 1'b0;
      rnum_nxt = '0;
    end else if (issue) begin
      rnum_nxt = rnum_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnum_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      rnum_r <= rnum_nxt;
    end
  end

  // Hold the block coordinates
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_word;
    end
  end

endmodule

// ===== src/t2ld_addr_pipe.sv =====
module t2ld_addr_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  t2ld_pkg::cfg_t      cfg,
  input  t2ld_pkg::row_req_t  req,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output t2ld_pkg::out_word_t out_word
);
  import t2ld_pkg::*;

  localparam int PLANE_W = 2 * DIM_W;
  localparam int IDX_W   = PLANE_W + 1;
  localparam int HI_W    = COORD_W;
  localparam int RUX_W   = 7;
  localparam int COLP_W  = 5;
  localparam int LOW_W   = 11;

  // ---------------- stage A: decode (combinational) ----------------
  logic [DIM_W-1:0]   w_a, h_a, wm1_a, hm1_a, row_ext_a, row32_a, rsum_a;
  logic [RUX_W-1:0]   rux_a;
  logic [9:0]         x_a;
  logic               last_odd_a;
  logic [COLP_W-1:0]  column_a;
  logic [1:0]         bank_a;
  logic [LOW_W-1:0]   low_a;

  always_comb begin
    w_a        = cfg.frame_width;
    h_a        = cfg.chroma_mode ? {1'b0, cfg.frame_height[DIM_W-1:1]} : cfg.frame_height;
    wm1_a      = w_a - 1'b1;
    hm1_a      = h_a - 1'b1;
    rux_a      = {1'b0, wm1_a[DIM_W-1:7]} + 1'b1;
    x_a        = req.col[COORD_W-1:2];
    row_ext_a  = {1'b0, req.row};
    row32_a    = row_ext_a + 13'd32;
    rsum_a     = row_ext_a + {{(DIM_W-ROW_CNT_W){1'b0}}, req.rnum};
    last_odd_a = (h_a <= row32_a) && (row_ext_a < h_a) && !hm1_a[5] && !req.row[5];
    column_a   = last_odd_a ? {1'b0, x_a[9:6]} : x_a[9:5];
    bank_a     = {x_a[5] ^ req.row[5], x_a[4]};
    low_a      = {req.row[4:0], x_a[3:0], 2'b00};
  end

  // ---------------- handshake chain ----------------
  logic vb_r, vc_r, vd_r;
  logic en_b, en_c, en_d;

  assign en_d = !vd_r || !out_stall;
  assign en_c = !vc_r || en_d;
  assign en_b = !vb_r || en_c;
  assign take = en_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_b) vb_r <= req.valid;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
    end
  end

  // ---------------- stage B: multiplies ----------------
  logic [PLANE_W-1:0]   idx_prod_b_r, plane_b_r;
  logic [HI_W-1:0]      hi_prod_b_r;
  logic [COLP_W-1:0]    column_b_r;
  logic [1:0]           bank_b_r;
  logic [LOW_W-1:0]     low_b_r;
  logic [ROW_CNT_W-1:0] rnum_b_r;
  logic [COORD_W-1:0]   col_b_r;
  logic                 last_b_r;
  logic [HI_W:0]        hi_prod_full;

  assign hi_prod_full = req.row[COORD_W-1:6] * rux_a;

  always_ff @(posedge clk) begin
    if (en_b && req.valid) begin
      idx_prod_b_r <= rsum_a * w_a;
      plane_b_r    <= w_a * h_a;
      hi_prod_b_r  <= hi_prod_full[HI_W-1:0];
      column_b_r   <= column_a;
      bank_b_r     <= bank_a;
      low_b_r      <= low_a;
      rnum_b_r     <= req.rnum;
      col_b_r      <= req.col;
      last_b_r     <= req.last;
    end
  end

  // ---------------- stage C: tile address and linear index ----------------
  logic [IDX_W-1:0]   idx_c_r;
  logic [PLANE_W-1:0] plane_c_r;
  logic [SRC_W-1:0]   src_c_r;
  logic               last_c_r;
  logic [HI_W-1:0]    high_c;
  logic [SRC_W-1:0]   base_c;

  assign high_c = hi_prod_b_r + {{(HI_W-COLP_W){1'b0}}, column_b_r};
  assign base_c = {high_c, bank_b_r, low_b_r};

  always_ff @(posedge clk) begin
    if (en_c && vb_r) begin
      idx_c_r   <= {1'b0, idx_prod_b_r} + {{(IDX_W-COORD_W){1'b0}}, col_b_r};
      plane_c_r <= plane_b_r;
      src_c_r   <= base_c + {{(SRC_W-ROW_CNT_W-6){1'b0}}, rnum_b_r, 6'b0};
      last_c_r  <= last_b_r;
    end
  end

  // ---------------- stage D: output word ----------------
  logic [IDX_W:0]     idx16_c;
  logic [PLANE_W-1:0] vsum_c;
  out_word_t          word_c, out_r;

  always_comb begin
    idx16_c             = {1'b0, idx_c_r} + 28'd16;
    vsum_c              = {1'b0, plane_c_r[PLANE_W-1:1]} + {1'b0, idx_c_r[PLANE_W-1:1]};
    word_c.src_offset   = src_c_r;
    word_c.dst_offset   = cfg.chroma_mode ? idx_c_r[DST_W:1] : idx_c_r[DST_W-1:0];
    word_c.v_dst_offset = cfg.chroma_mode ? vsum_c[DST_W-1:0] : '0;
    word_c.skip_row     = idx16_c > {2'b00, plane_c_r};
    word_c.last_row     = last_c_r;
  end

  always_ff @(posedge clk) begin
    if (en_d && vc_r) begin
      out_r <= word_c;
    end
  end

  assign out_valid = vd_r;
  assign out_word  = out_r;

endmodule

// ===== src/tiled_to_linear_detile_addr.sv =====
// Channel  | Handshake            | Word
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_stall  | in_word: block_col, block_row
// out      | out_valid / out_stall| out_word: src, dst, v_dst, skip, last
// cfg      | APB psel/penable     | frame_width, frame_height, chroma_mode
//
// Each input word yields 16 output words, one per cycle while out_stall is low,
// issued by the row sequencer; the next block is taken on the cycle its last row issues.
// A row reaches the output through the sequencer register, stage B, stage C and
// the output register.
// Reset (synchronous, rst_n low) empties the sequencer and the pipeline.
// out_stall freezes the pipeline and, once it backs up, the sequencer.
module tiled_to_linear_detile_addr (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  t2ld_pkg::in_word_t                   in_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output t2ld_pkg::out_word_t                  out_word,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [t2ld_pkg::PADDR_W-1:0]         paddr,
  input  logic [t2ld_pkg::PDATA_W-1:0]         pwdata,
  output logic [t2ld_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);
  import t2ld_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  row_req_t req;
  logic     take;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= FRAME_WIDTH_RST;
      cfg_r.frame_height <= FRAME_HEIGHT_RST;
      cfg_r.chroma_mode  <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[DIM_W-1:0];
        REG_CHROMA_MODE:  cfg_r.chroma_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = {{(PDATA_W-DIM_W){1'b0}}, cfg_r.frame_width};
      REG_FRAME_HEIGHT: prdata = {{(PDATA_W-DIM_W){1'b0}}, cfg_r.frame_height};
      REG_CHROMA_MODE:  prdata = {{(PDATA_W-1){1'b0}}, cfg_r.chroma_mode};
      default:          prdata = '0;
    endcase
  end

  t2ld_row_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .take     (take),
    .req      (req)
  );

  t2ld_addr_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req       (req),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== src/t2ld_port_chk.sv =====
`include "tiled_to_linear_detile_addr_macros.svh"

module t2ld_port_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input t2ld_pkg::out_word_t out_word
);
  import t2ld_pkg::*;

  // Hold a stalled word
  `T2LD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled word dropped")
  `T2LD_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_word), "stalled word changed")
  // Consecutive rows of one block step the tiled offset by one row
  `T2LD_ASSERT(a_src_step,
               (out_valid && !out_stall && !out_word.last_row) ##1 out_valid |->
               out_word.src_offset == $past(out_word.src_offset) + 25'd64,
               "tiled offset did not advance by a row")
  // A block occupies the sequencer right after it is taken
  `T2LD_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second word taken")
  // Empty the output on reset
  `T2LD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind tiled_to_linear_detile_addr t2ld_port_chk u_port_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
